/* hdl/vitr_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// vitr_pkg
// Shared widths, item codes and register map of the interface adapter with
// its timer 1 block.
// ============================================================================
package vitr_pkg;

    // Field widths of one request beat and one response beat, and of the flag registers
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FLAG_W  = 7;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Register map
    localparam logic [ADDR_W-1:0] REG_PORTB     = 4'h0;
    localparam logic [ADDR_W-1:0] REG_PORTA     = 4'h1;
    localparam logic [ADDR_W-1:0] REG_DDRB      = 4'h2;
    localparam logic [ADDR_W-1:0] REG_DDRA      = 4'h3;
    localparam logic [ADDR_W-1:0] REG_T1_CNT_LO = 4'h4;
    localparam logic [ADDR_W-1:0] REG_T1_CNT_HI = 4'h5;
    localparam logic [ADDR_W-1:0] REG_T1_LAT_LO = 4'h6;
    localparam logic [ADDR_W-1:0] REG_T1_LAT_HI = 4'h7;
    localparam logic [ADDR_W-1:0] REG_T2_LO     = 4'h8;
    localparam logic [ADDR_W-1:0] REG_T2_HI     = 4'h9;
    localparam logic [ADDR_W-1:0] REG_SHIFT     = 4'hA;
    localparam logic [ADDR_W-1:0] REG_ACR       = 4'hB;
    localparam logic [ADDR_W-1:0] REG_PCR       = 4'hC;
    localparam logic [ADDR_W-1:0] REG_IFR       = 4'hD;
    localparam logic [ADDR_W-1:0] REG_IER       = 4'hE;
    localparam logic [ADDR_W-1:0] REG_PORTA_NH  = 4'hF;

    // Bit masks
    localparam logic [FLAG_W-1:0] FLAG_T1      = 7'h40;
    localparam logic [BYTE_W-1:0] PORTB_MID    = 8'h7E;
    localparam logic [BYTE_W-1:0] ALL_OUTPUT   = 8'hFF;
    localparam int unsigned       ACR_FREE_RUN = 6;

endpackage

/* hdl/vitr_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// vitr_req_if / vitr_rsp_if
// Valid/ready channels for request beats (read, write, tick) and response
// beats of the adapter.
// ============================================================================
interface vitr_req_if;
    logic                              valid;
    logic                              ready;
    logic [vitr_pkg::FUNC_W-1:0]       func;
    logic [vitr_pkg::ADDR_W-1:0]       reg_addr;
    logic [vitr_pkg::BYTE_W-1:0]       write_data;
    logic [vitr_pkg::COUNT_W-1:0]      tick_cycles;

    modport source (output valid, func, reg_addr, write_data, tick_cycles, input ready);
    modport sink   (input valid, func, reg_addr, write_data, tick_cycles, output ready);
endinterface

interface vitr_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [vitr_pkg::BYTE_W-1:0]       read_data;
    logic                              irq;
    logic                              sent_valid;
    logic [vitr_pkg::BYTE_W-1:0]       sent_byte;

    modport source (output valid, read_data, irq, sent_valid, sent_byte, input ready);
    modport sink   (input valid, read_data, irq, sent_valid, sent_byte, output ready);
endinterface

/* hdl/versatile_interface_timer_registers_core.sv */
`timescale 1ns / 1ps
// Path: a request beat passes the input register, then the register update
//   and the response register; both hold while the response is not taken.
// Throughput: one beat per cycle unless rsp.ready is low; the register update
//   is a single pass of decode, one 16-bit compare and one subtract.
// Reset: rst_n zeroes the valid flags, state registers, timer and strobes.
// ============================================================================
// versatile_interface_timer_registers_core
// Sixteen-register interface adapter with timer 1, interrupt flags and the
// port B strobe / port A handoff.
// ============================================================================
module versatile_interface_timer_registers_core (
    input  logic            clk,
    input  logic            rst_n,
    vitr_req_if.sink        req,
    vitr_rsp_if.source      rsp
);

    // ---------------- input stage ----------------
    logic                              s1_valid_reg;
    vitr_pkg::func_t                   s1_func_reg;
    logic [vitr_pkg::ADDR_W-1:0]       s1_addr_reg;
    logic [vitr_pkg::BYTE_W-1:0]       s1_data_reg;
    logic [vitr_pkg::COUNT_W-1:0]      s1_cycles_reg;

    // ---------------- response register ----------------
    logic                              out_valid_reg;
    logic [vitr_pkg::BYTE_W-1:0]       out_rdata_reg;
    logic                              out_irq_reg;
    logic                              out_sent_reg;
    logic [vitr_pkg::BYTE_W-1:0]       out_sbyte_reg;

    // ---------------- architectural state ----------------
    logic [vitr_pkg::BYTE_W-1:0]  port_b_out_reg,  port_b_out_next;
    logic [vitr_pkg::BYTE_W-1:0]  port_a_data_reg, port_a_data_next;
    logic [vitr_pkg::BYTE_W-1:0]  port_b_dir_reg,  port_b_dir_next;
    logic [vitr_pkg::BYTE_W-1:0]  port_a_dir_reg,  port_a_dir_next;
    logic [vitr_pkg::BYTE_W-1:0]  t1_lat_lo_reg,   t1_lat_lo_next;
    logic [vitr_pkg::BYTE_W-1:0]  t1_lat_hi_reg,   t1_lat_hi_next;
    logic [vitr_pkg::BYTE_W-1:0]  t2_lo_reg,       t2_lo_next;
    logic [vitr_pkg::BYTE_W-1:0]  t2_hi_reg,       t2_hi_next;
    logic [vitr_pkg::BYTE_W-1:0]  shift_reg,       shift_next;
    logic [vitr_pkg::BYTE_W-1:0]  acr_reg,         acr_next;
    logic [vitr_pkg::BYTE_W-1:0]  pcr_reg,         pcr_next;
    logic [vitr_pkg::FLAG_W-1:0]  flags_reg,       flags_next;
    logic [vitr_pkg::FLAG_W-1:0]  enables_reg,     enables_next;
    logic [vitr_pkg::COUNT_W-1:0] t1_count_reg,    t1_count_next;
    logic                         t1_active_reg,   t1_active_next;
    logic                         host_stb_reg,    host_stb_next;
    logic                         ack_stb_reg,     ack_stb_next;

    // Response of the beat in the input stage
    logic [vitr_pkg::BYTE_W-1:0]  rdata;
    logic                         sent;
    logic [vitr_pkg::BYTE_W-1:0]  sbyte;
    logic                         irq_any;

    logic out_free;
    logic step;

    // Handshake: the input stage moves when the response slot is free
    assign out_free  = !out_valid_reg || rsp.ready;
    assign step      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_rdata_reg;
    assign rsp.irq        = out_irq_reg;
    assign rsp.sent_valid = out_sent_reg;
    assign rsp.sent_byte  = out_sbyte_reg;

    // Register access, strobe handoff and timer 1
    always_comb
    begin
        port_b_out_next  = port_b_out_reg;
        port_a_data_next = port_a_data_reg;
        port_b_dir_next  = port_b_dir_reg;
        port_a_dir_next  = port_a_dir_reg;
        t1_lat_lo_next   = t1_lat_lo_reg;
        t1_lat_hi_next   = t1_lat_hi_reg;
        t2_lo_next       = t2_lo_reg;
        t2_hi_next       = t2_hi_reg;
        shift_next       = shift_reg;
        acr_next         = acr_reg;
        pcr_next         = pcr_reg;
        flags_next       = flags_reg;
        enables_next     = enables_reg;
        t1_count_next    = t1_count_reg;
        t1_active_next   = t1_active_reg;
        host_stb_next    = host_stb_reg;
        ack_stb_next     = ack_stb_reg;
        rdata            = '0;
        sent             = 1'b0;
        sbyte            = '0;

        unique case (s1_func_reg)
            vitr_pkg::FUNC_READ:
            begin
                unique case (s1_addr_reg) inside
                    vitr_pkg::REG_PORTB:
                        rdata = (port_b_out_reg & vitr_pkg::PORTB_MID)
                              | {ack_stb_reg, 6'b0, host_stb_reg};
                    vitr_pkg::REG_PORTA, vitr_pkg::REG_PORTA_NH:
                        rdata = port_a_data_reg;
                    vitr_pkg::REG_DDRB:      rdata = port_b_dir_reg;
                    vitr_pkg::REG_DDRA:      rdata = port_a_dir_reg;
                    vitr_pkg::REG_T1_CNT_LO:
                    begin
                        rdata      = t1_count_reg[7:0];
                        flags_next = flags_reg & ~vitr_pkg::FLAG_T1;
                    end
                    vitr_pkg::REG_T1_CNT_HI: rdata = t1_count_reg[15:8];
                    vitr_pkg::REG_T1_LAT_LO: rdata = t1_lat_lo_reg;
                    vitr_pkg::REG_T1_LAT_HI: rdata = t1_lat_hi_reg;
                    vitr_pkg::REG_T2_LO:     rdata = t2_lo_reg;
                    vitr_pkg::REG_T2_HI:     rdata = t2_hi_reg;
                    vitr_pkg::REG_SHIFT:     rdata = shift_reg;
                    vitr_pkg::REG_ACR:       rdata = acr_reg;
                    vitr_pkg::REG_PCR:       rdata = pcr_reg;
                    vitr_pkg::REG_IFR:
                        rdata = {|(flags_reg & enables_reg), flags_reg};
                    vitr_pkg::REG_IER:       rdata = {1'b1, enables_reg};
                    default:                 rdata = port_a_data_reg;
                endcase
            end

            vitr_pkg::FUNC_WRITE:
            begin
                unique case (s1_addr_reg) inside
                    vitr_pkg::REG_PORTB:
                    begin
                        host_stb_next   = s1_data_reg[0];
                        port_b_out_next = (port_b_out_reg & ~port_b_dir_reg)
                                        | (s1_data_reg & port_b_dir_reg);
                        // rising strobe: hand off port A only if all-output
                        if (!host_stb_reg && s1_data_reg[0])
                        begin
                            if (port_a_dir_reg == vitr_pkg::ALL_OUTPUT)
                            begin
                                sent         = 1'b1;
                                sbyte        = port_a_data_reg;
                                ack_stb_next = 1'b1;
                            end
                            else
                            begin
                                ack_stb_next = 1'b0;
                            end
                        end
                        if (host_stb_reg && !s1_data_reg[0])
                            ack_stb_next = 1'b0;
                    end
                    vitr_pkg::REG_PORTA, vitr_pkg::REG_PORTA_NH:
                        port_a_data_next = s1_data_reg;
                    vitr_pkg::REG_DDRB:      port_b_dir_next = s1_data_reg;
                    vitr_pkg::REG_DDRA:      port_a_dir_next = s1_data_reg;
                    vitr_pkg::REG_T1_CNT_LO, vitr_pkg::REG_T1_LAT_LO:
                        t1_lat_lo_next = s1_data_reg;
                    vitr_pkg::REG_T1_CNT_HI:
                    begin
                        t1_lat_hi_next = s1_data_reg;
                        t1_count_next  = {s1_data_reg, t1_lat_lo_reg};
                        t1_active_next = 1'b1;
                        flags_next     = flags_reg & ~vitr_pkg::FLAG_T1;
                    end
                    vitr_pkg::REG_T1_LAT_HI: t1_lat_hi_next = s1_data_reg;
                    vitr_pkg::REG_T2_LO:     t2_lo_next = s1_data_reg;
                    vitr_pkg::REG_T2_HI:     t2_hi_next = s1_data_reg;
                    vitr_pkg::REG_SHIFT:     shift_next = s1_data_reg;
                    vitr_pkg::REG_ACR:       acr_next = s1_data_reg;
                    vitr_pkg::REG_PCR:       pcr_next = s1_data_reg;
                    vitr_pkg::REG_IFR:
                        flags_next = flags_reg & ~s1_data_reg[6:0];
                    vitr_pkg::REG_IER:
                    begin
                        // bit 7 selects set or clear
                        if (s1_data_reg[7])
                            enables_next = enables_reg | s1_data_reg[6:0];
                        else
                            enables_next = enables_reg & ~s1_data_reg[6:0];
                    end
                    default:                 port_a_data_next = s1_data_reg;
                endcase
            end

            vitr_pkg::FUNC_TICK:
            begin
                if (t1_active_reg && (s1_cycles_reg != '0))
                begin
                    if (s1_cycles_reg >= t1_count_reg)
                    begin
                        // expiry: reload in free-run, else stop
                        flags_next = flags_reg | vitr_pkg::FLAG_T1;
                        if (acr_reg[vitr_pkg::ACR_FREE_RUN])
                        begin
                            t1_count_next = {t1_lat_hi_reg, t1_lat_lo_reg};
                        end
                        else
                        begin
                            t1_active_next = 1'b0;
                            t1_count_next  = '0;
                        end
                    end
                    else
                    begin
                        t1_count_next = t1_count_reg - s1_cycles_reg;
                    end
                end
            end

            default:
            begin
                // unused item code: no change
            end
        endcase

        irq_any = |(flags_next & enables_next);
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            port_b_out_reg  <= '0;
            port_a_data_reg <= '0;
            port_b_dir_reg  <= '0;
            port_a_dir_reg  <= '0;
            t1_lat_lo_reg   <= '0;
            t1_lat_hi_reg   <= '0;
            t2_lo_reg       <= '0;
            t2_hi_reg       <= '0;
            shift_reg       <= '0;
            acr_reg         <= '0;
            pcr_reg         <= '0;
            flags_reg       <= '0;
            enables_reg     <= '0;
            t1_count_reg    <= '0;
            t1_active_reg   <= 1'b0;
            host_stb_reg    <= 1'b0;
            ack_stb_reg     <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (step)
            begin
                port_b_out_reg  <= port_b_out_next;
                port_a_data_reg <= port_a_data_next;
                port_b_dir_reg  <= port_b_dir_next;
                port_a_dir_reg  <= port_a_dir_next;
                t1_lat_lo_reg   <= t1_lat_lo_next;
                t1_lat_hi_reg   <= t1_lat_hi_next;
                t2_lo_reg       <= t2_lo_next;
                t2_hi_reg       <= t2_hi_next;
                shift_reg       <= shift_next;
                acr_reg         <= acr_next;
                pcr_reg         <= pcr_next;
                flags_reg       <= flags_next;
                enables_reg     <= enables_next;
                t1_count_reg    <= t1_count_next;
                t1_active_reg   <= t1_active_next;
                host_stb_reg    <= host_stb_next;
                ack_stb_reg     <= ack_stb_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg   <= vitr_pkg::func_t'(req.func);
            s1_addr_reg   <= req.reg_addr;
            s1_data_reg   <= req.write_data;
            s1_cycles_reg <= req.tick_cycles;
        end
        if (step)
        begin
            out_rdata_reg <= rdata;
            out_irq_reg   <= irq_any;
            out_sent_reg  <= sent;
            out_sbyte_reg <= sbyte;
        end
    end

    // ---------------- assertions ----------------
    a_stopped_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !t1_active_reg |-> (t1_count_reg == '0))
        else $error("timer 1 stopped with a nonzero count");

    a_ack_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ack_stb_reg |-> host_stb_reg)
        else $error("acknowledge strobe high while host strobe low");

    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_irq_reg == (|(flags_reg & enables_reg))))
        else $error("response irq disagrees with flag state");

    a_no_byte_unsent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_sent_reg) |-> (out_sbyte_reg == '0))
        else $error("sent byte nonzero without a handoff");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("input stage dropped a beat under backpressure");

endmodule
